// ----- src/clex_pkg.sv -----
// Shared types, token codes and keyword tables for the C subset lexer.
// No dependencies.
package clex_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_DEC, M_ZERO, M_HEX, M_IDENT, M_STR,
        M_SLASH, M_LINE, M_BLOCK, M_STAR, M_OP
    } t_mode;

    localparam logic [5:0] K_NUM   = 6'd0;
    localparam logic [5:0] K_ID    = 6'd1;
    localparam logic [5:0] K_STR   = 6'd2;
    localparam logic [5:0] K_KW0   = 6'd3;
    localparam logic [5:0] K_PLUS  = 6'd10;
    localparam logic [5:0] K_MINUS = 6'd11;
    localparam logic [5:0] K_MUL   = 6'd12;
    localparam logic [5:0] K_DIV   = 6'd13;
    localparam logic [5:0] K_ASSIGN = 6'd14;
    localparam logic [5:0] K_EQ    = 6'd15;
    localparam logic [5:0] K_NE    = 6'd16;
    localparam logic [5:0] K_LT    = 6'd17;
    localparam logic [5:0] K_GT    = 6'd18;
    localparam logic [5:0] K_LE    = 6'd19;
    localparam logic [5:0] K_GE    = 6'd20;
    localparam logic [5:0] K_LAND  = 6'd21;
    localparam logic [5:0] K_LOR   = 6'd22;
    localparam logic [5:0] K_AMP   = 6'd23;
    localparam logic [5:0] K_SEMI  = 6'd24;
    localparam logic [5:0] K_COMMA = 6'd25;
    localparam logic [5:0] K_LPAR  = 6'd26;
    localparam logic [5:0] K_RPAR  = 6'd27;
    localparam logic [5:0] K_LBRC  = 6'd28;
    localparam logic [5:0] K_RBRC  = 6'd29;
    localparam logic [5:0] K_LBRK  = 6'd30;
    localparam logic [5:0] K_RBRK  = 6'd31;
    localparam logic [5:0] K_END   = 6'd32;
    localparam logic [5:0] K_ERR   = 6'd33;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic        last;
    } t_token;

    // int, void, if, else, while, for, return
    localparam logic [7:0] KW_TEXT [7][6] = '{
        '{"i", "n", "t", 8'h0, 8'h0, 8'h0},
        '{"v", "o", "i", "d", 8'h0, 8'h0},
        '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"e", "l", "s", "e", 8'h0, 8'h0},
        '{"w", "h", "i", "l", "e", 8'h0},
        '{"f", "o", "r", 8'h0, 8'h0, 8'h0},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [7:0] KW_LEN [7] = '{8'd3, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6};

    // keywords still matching once byte c sits at position pos
    function automatic logic [6:0] kw_hits(input logic [7:0] pos, input logic [7:0] c);
        logic [6:0] m;
        m = '0;
        for (int k = 0; k < 7; k++) begin
            if (pos < KW_LEN[k] && KW_TEXT[k][pos[2:0]] == c) m[k] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [6:0] km, input logic [7:0] cnt);
        logic [5:0] r;
        r = K_ID;
        for (int k = 6; k >= 0; k--) begin
            if (km[k] && KW_LEN[k] == cnt) r = K_KW0 + 6'(k);
        end
        return r;
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] a);
        logic [5:0] r;
        case (a)
            "=":     r = K_ASSIGN;
            "<":     r = K_LT;
            ">":     r = K_GT;
            "&":     r = K_AMP;
            default: r = K_ERR;
        endcase
        return r;
    endfunction

    // zero where the pair forms no operator
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] r;
        r = '0;
        if (b == "=") begin
            case (a)
                "=":     r = K_EQ;
                "!":     r = K_NE;
                "<":     r = K_LE;
                ">":     r = K_GE;
                default: r = '0;
            endcase
        end
        if (a == "&" && b == "&") r = K_LAND;
        if (a == "|" && b == "|") r = K_LOR;
        return r;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            "+":     r = K_PLUS;
            "-":     r = K_MINUS;
            "*":     r = K_MUL;
            ";":     r = K_SEMI;
            ",":     r = K_COMMA;
            "(":     r = K_LPAR;
            ")":     r = K_RPAR;
            "{":     r = K_LBRC;
            "}":     r = K_RBRC;
            "[":     r = K_LBRK;
            "]":     r = K_RBRK;
            default: r = K_ERR;
        endcase
        return r;
    endfunction

endpackage

// ----- src/clex_if.sv -----
// Handshake interfaces for source bytes and tokens.
// No dependencies.
interface clex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;
    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface clex_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  lexeme_length;
    logic        last_result;
    modport source (output valid, output token_kind, output start_line, output start_column,
                    output lexeme_length, output last_result, input ready);
    modport sink (input valid, input token_kind, input start_line, input start_column,
                  input lexeme_length, input last_result, output ready);
endinterface

// ----- src/clex_fifo.sv -----
// Four-word token queue, up to two pushes per cycle, one pop.
// Depends on clex_pkg.
module clex_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0,
    input  logic             i_push1,
    input  clex_pkg::t_token i_tok0,
    input  clex_pkg::t_token i_tok1,
    output logic             o_room2,
    output logic             o_valid,
    output clex_pkg::t_token o_tok,
    input  logic             i_pop
);
    import clex_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign pop     = i_pop && (r_cnt != 3'd0);
    assign o_valid = r_cnt != 3'd0;
    assign o_tok   = r_mem[r_rd];
    assign o_room2 = r_cnt <= 3'd2;

    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wr] <= i_tok0;
        if (i_push1) r_mem[r_wr + 2'd1] <= i_tok1;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + {1'b0, i_push0} + {1'b0, i_push1};
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {2'b0, i_push0} + {2'b0, i_push1} - {2'b0, pop};
        end
    end
endmodule

// ----- src/c_subset_lexer.sv -----
// Streaming lexer for a C subset: one source byte per word, tokens out.
// A token is queued when the byte that closes it is taken.
// Throughput: one byte a cycle; a byte may yield two tokens, queued in a
// four-word queue whose free space (at least two words) gates input ready.
// Reset (synchronous, active low): idle, position line 1 column 1, queue empty.
// End of text also returns the scanner to its reset state.
module c_subset_lexer #(
    parameter int MAX_LEXEME    = 256,
    parameter int POSITION_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    clex_in_if.sink    i_src,
    clex_out_if.source o_tok
);
    import clex_pkg::*;

    localparam int LEX_LIMIT_I = (MAX_LEXEME - 1 > 255) ? 255 : MAX_LEXEME - 1;
    localparam logic [7:0] LEX_LIMIT = 8'(LEX_LIMIT_I);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // scanner state
    t_mode                  r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [POSITION_BITS-1:0] r_tline, n_tline, r_tcol, n_tcol;
    logic [7:0]             r_cnt, n_cnt;
    logic [6:0]             r_km, n_km;
    logic [7:0]             r_held, n_held;
    logic                   r_halt, n_halt;

    logic       take, eot, again, is_dig, is_alp, is_hexd, is_sp;
    logic [7:0] c;
    logic       a_v, b_v;
    logic [5:0] a_k, b_k, k;
    logic [7:0] a_len, b_len;
    logic       room2, push0, push1;
    t_token     ta, tb, t0, t1, head;

    assign c       = i_src.char_byte;
    assign take    = i_src.valid && i_src.ready;
    assign eot     = i_src.end_of_text || (c == 8'd0);
    assign is_dig  = c >= "0" && c <= "9";
    assign is_alp  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_hexd = is_dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    assign is_sp   = c == " " || (c >= 8'd9 && c <= 8'd13);

    always_comb begin
        n_mode = r_mode; n_line = r_line; n_col = r_col;
        n_tline = r_tline; n_tcol = r_tcol; n_cnt = r_cnt;
        n_km = r_km; n_held = r_held; n_halt = r_halt;
        a_v = 1'b0; a_k = K_NUM; a_len = r_cnt;
        b_v = 1'b0; b_k = K_END; b_len = 8'd0;
        again = 1'b0; k = '0;
        if (eot) begin
            // flush held token, then end token at the current position
            if (!r_halt) begin
                case (r_mode)
                    M_DEC, M_ZERO, M_HEX: a_v = 1'b1;
                    M_IDENT: begin a_v = 1'b1; a_k = ident_kind(r_km, r_cnt); end
                    M_STR:   begin a_v = 1'b1; a_k = K_STR; end
                    M_SLASH: begin a_v = 1'b1; a_k = K_DIV; a_len = 8'd1; end
                    M_OP:    begin a_v = 1'b1; a_k = lone_kind(r_held); a_len = 8'd1; end
                    default: a_v = 1'b0;
                endcase
            end
            b_v = 1'b1;
            n_mode = M_IDLE; n_line = POS_ONE; n_col = POS_ONE;
            n_tline = POS_ONE; n_tcol = POS_ONE; n_cnt = '0;
            n_km = '1; n_held = '0; n_halt = 1'b0;
        end else if (!r_halt) begin
            case (r_mode)
                M_DEC: begin
                    if (is_dig && r_cnt < LEX_LIMIT) n_cnt = r_cnt + 8'd1;
                    else begin a_v = 1'b1; again = 1'b1; end
                end
                M_ZERO: begin
                    if (c == "x" || c == "X") begin n_cnt = 8'd2; n_mode = M_HEX; end
                    else if (is_dig) begin n_cnt = 8'd2; n_mode = M_DEC; end
                    else begin a_v = 1'b1; again = 1'b1; end
                end
                M_HEX: begin
                    if (is_hexd && r_cnt < LEX_LIMIT) n_cnt = r_cnt + 8'd1;
                    else begin a_v = 1'b1; again = 1'b1; end
                end
                M_IDENT: begin
                    if ((is_alp || is_dig || c == "_") && r_cnt < LEX_LIMIT) begin
                        n_km  = r_km & kw_hits(r_cnt, c);
                        n_cnt = r_cnt + 8'd1;
                    end else begin
                        a_v = 1'b1; a_k = ident_kind(r_km, r_cnt); again = 1'b1;
                    end
                end
                M_STR: begin
                    a_k = K_STR;
                    if (c == "\"") begin a_v = 1'b1; n_mode = M_IDLE; end
                    else if (r_cnt < LEX_LIMIT) n_cnt = r_cnt + 8'd1;
                    else begin a_v = 1'b1; again = 1'b1; end
                end
                M_SLASH: begin
                    if (c == "/") n_mode = M_LINE;
                    else if (c == "*") n_mode = M_BLOCK;
                    else begin a_v = 1'b1; a_k = K_DIV; a_len = 8'd1; again = 1'b1; end
                end
                M_LINE:  if (c == 8'd10) n_mode = M_IDLE;
                M_BLOCK: if (c == "*") n_mode = M_STAR;
                M_STAR: begin
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BLOCK;
                end
                M_OP: begin
                    k = pair_kind(r_held, c);
                    a_v = 1'b1;
                    if (k != '0) begin a_k = k; a_len = 8'd2; n_mode = M_IDLE; end
                    else begin
                        a_k = lone_kind(r_held); a_len = 8'd1;
                        if (a_k == K_ERR) begin n_halt = 1'b1; n_mode = M_IDLE; end
                        else again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase
            if (again) begin
                // new token starts at this byte
                n_mode = M_IDLE;
                if (!is_sp) begin
                    n_tline = r_line; n_tcol = r_col;
                    if (is_dig) begin
                        n_cnt = 8'd1;
                        n_mode = (c == "0") ? M_ZERO : M_DEC;
                    end else if (is_alp || c == "_") begin
                        n_km = kw_hits(8'd0, c); n_cnt = 8'd1; n_mode = M_IDENT;
                    end else if (c == "\"") begin
                        n_cnt = 8'd0; n_mode = M_STR;
                    end else if (c == "/") begin
                        n_mode = M_SLASH;
                    end else if (c == "=" || c == "!" || c == "<" || c == ">"
                                 || c == "&" || c == "|") begin
                        n_held = c; n_mode = M_OP;
                    end else begin
                        b_v = 1'b1; b_k = single_kind(c); b_len = 8'd1;
                        if (b_k == K_ERR) n_halt = 1'b1;
                    end
                end
            end
            // position of the next byte, saturating
            if (c == 8'd10) begin
                if (r_line != POS_MAX) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end
    end

    // closing token carries the held start; a new or end token the current spot
    assign ta = '{kind: a_k, line: 16'(r_tline), column: 16'(r_tcol),
                  length: a_len, last: !b_v};
    assign tb = '{kind: b_k, line: 16'(r_line), column: 16'(r_col),
                  length: b_len, last: 1'b1};
    assign t0    = a_v ? ta : tb;
    assign t1    = tb;
    assign push0 = take && (a_v || b_v);
    assign push1 = take && a_v && b_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= POS_ONE; r_col <= POS_ONE;
            r_tline <= POS_ONE; r_tcol <= POS_ONE; r_cnt <= '0;
            r_km <= '1; r_held <= '0; r_halt <= 1'b0;
        end else if (take) begin
            r_mode <= n_mode; r_line <= n_line; r_col <= n_col;
            r_tline <= n_tline; r_tcol <= n_tcol; r_cnt <= n_cnt;
            r_km <= n_km; r_held <= n_held; r_halt <= n_halt;
        end
    end

    clex_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_tok0  (t0),
        .i_tok1  (t1),
        .o_room2 (room2),
        .o_valid (o_tok.valid),
        .o_tok   (head),
        .i_pop   (o_tok.ready)
    );

    assign i_src.ready         = room2;
    assign o_tok.token_kind    = head.kind;
    assign o_tok.start_line    = head.line;
    assign o_tok.start_column  = head.column;
    assign o_tok.lexeme_length = head.length;
    assign o_tok.last_result   = head.last;
endmodule
